>>> rtl/mlsm_pkg.sv
// Shared types and codes for the mutex lock cell.
package mlsm_pkg;

	// Request codes carried by req_type.
	typedef enum logic [1:0] {
		REQ_LOCK    = 2'd0,
		REQ_TRYLOCK = 2'd1,
		REQ_UNLOCK  = 2'd2,
		REQ_CONSIST = 2'd3
	} req_code_t;

	// Status codes returned with every result.
	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_INVALID   = 4'd1,
		ST_DEADLOCK  = 4'd2,
		ST_BUSY      = 4'd3,
		ST_OWNERDEAD = 4'd4,
		ST_NOTPERM   = 4'd5,
		ST_USAGE     = 4'd6,
		ST_WAIT      = 4'd7,
		ST_UNSUPP    = 4'd8
	} status_t;

	// Mutex type codes; the unassigned code behaves as normal.
	localparam logic [1:0] MTYPE_NORMAL    = 2'd0;
	localparam logic [1:0] MTYPE_ERRCHECK  = 2'd1;
	localparam logic [1:0] MTYPE_RECURSIVE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MUTEX_TYPE = 2'd0;
	localparam logic [1:0] CFG_ROBUST     = 2'd1;
	localparam logic [1:0] CFG_TRYLOCK    = 2'd2;
	localparam int unsigned CFG_DATA_BITS = 2;

	// Robustness state machine, one-hot.
	typedef enum logic [2:0] {
		RS_NORMAL       = 3'b001,
		RS_INCONSISTENT = 3'b010,
		RS_UNUSABLE     = 3'b100
	} robust_state_t;

	// Configuration seen by the lock cell.
	typedef struct packed {
		logic [1:0] mutex_type;
		logic       robust_mode;
		logic       trylock_enabled;
	} cfg_t;

endpackage

>>> rtl/mlsm_ifs.sv
// Request and result channel interfaces of the mutex lock cell.
interface mlsm_req_if #(
	parameter int unsigned ID_BITS = 8
);
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [ID_BITS-1:0] requester_id;
	logic               owner_alive;
	logic               force_release;

	modport source (output valid, req_type, requester_id, owner_alive, force_release,
		input ready);
	modport sink (input valid, req_type, requester_id, owner_alive, force_release,
		output ready);
endinterface

interface mlsm_rsp_if #(
	parameter int unsigned ID_BITS    = 8,
	parameter int unsigned COUNT_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [3:0]            status;
	logic                  held_now;
	logic [ID_BITS-1:0]    owner_now;
	logic [COUNT_BITS-1:0] count_now;

	modport source (output valid, status, held_now, owner_now, count_now, input ready);
	modport sink (input valid, status, held_now, owner_now, count_now, output ready);
endinterface

>>> rtl/mlsm_cell.sv
// Lock cell: mutex state registers and the per-request decision logic.
module mlsm_cell
	import mlsm_pkg::*;
#(
	parameter int unsigned ID_BITS    = 8,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  fire,
	input  logic [1:0]            req_type,
	input  logic [ID_BITS-1:0]    requester_id,
	input  logic                  owner_alive,
	input  logic                  force_release,
	output status_t               status,
	output logic                  held_now,
	output logic [ID_BITS-1:0]    owner_now,
	output logic [COUNT_BITS-1:0] count_now
);

	logic                  held_q;
	logic [ID_BITS-1:0]    owner_q;
	logic [COUNT_BITS-1:0] count_q;
	robust_state_t         rstate_q;

	logic                  held_d;
	logic [ID_BITS-1:0]    owner_d;
	logic [COUNT_BITS-1:0] count_d;
	robust_state_t         rstate_d;

	logic is_errchk;
	logic is_recur;
	logic is_plain;
	logic is_owner;
	logic do_free;

	assign is_errchk = (cfg.mutex_type == MTYPE_ERRCHECK);
	assign is_recur  = (cfg.mutex_type == MTYPE_RECURSIVE);
	assign is_plain  = !is_errchk && !is_recur && !cfg.robust_mode && !cfg.trylock_enabled;
	assign is_owner  = held_q && (owner_q == requester_id);

	// Decide the status and the next contents of the cell for one request.
	always_comb begin
		held_d   = held_q;
		owner_d  = owner_q;
		count_d  = count_q;
		rstate_d = rstate_q;
		status   = ST_OK;
		do_free  = 1'b0;
		unique case (req_code_t'(req_type))
			REQ_LOCK, REQ_TRYLOCK: begin
				if (req_type == REQ_TRYLOCK && is_plain) begin
					status = ST_UNSUPP;
				end else if (cfg.robust_mode && rstate_q == RS_UNUSABLE) begin
					status = ST_INVALID;
				end else if (!held_q) begin
					held_d  = 1'b1;
					owner_d = requester_id;
					count_d = COUNT_BITS'(1);
				end else if (owner_q == requester_id) begin
					if (is_errchk) begin
						status = ST_DEADLOCK;
					end else if (is_recur) begin
						// Saturated count refuses the relock.
						if (&count_q) begin
							status = ST_BUSY;
						end else begin
							count_d = count_q + COUNT_BITS'(1);
						end
					end else begin
						status = ST_USAGE;
					end
				end else if (cfg.robust_mode && !owner_alive) begin
					// Take over a dead owner's lock.
					rstate_d = RS_INCONSISTENT;
					owner_d  = requester_id;
					count_d  = COUNT_BITS'(1);
					status   = ST_OWNERDEAD;
				end else begin
					status = (req_type == REQ_LOCK) ? ST_WAIT : ST_BUSY;
				end
			end
			REQ_UNLOCK: begin
				if (!is_owner) begin
					status = is_errchk ? ST_NOTPERM : ST_USAGE;
				end else begin
					if (is_recur) begin
						count_d = count_q - COUNT_BITS'(1);
						do_free = (count_q == COUNT_BITS'(1)) || force_release;
					end else begin
						do_free = 1'b1;
					end
					if (do_free) begin
						if (cfg.robust_mode && rstate_q == RS_INCONSISTENT) begin
							rstate_d = RS_UNUSABLE;
						end
						held_d  = 1'b0;
						owner_d = '0;
						count_d = '0;
					end
				end
			end
			REQ_CONSIST: begin
				if (!cfg.robust_mode || !is_owner || rstate_q != RS_INCONSISTENT) begin
					status = ST_INVALID;
				end else begin
					rstate_d = RS_NORMAL;
				end
			end
			default: begin
				status = ST_INVALID;
			end
		endcase
	end

	assign held_now  = held_d;
	assign owner_now = owner_d;
	assign count_now = count_d;

	// State registers change only when a request is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 1'b0;
			owner_q  <= '0;
			count_q  <= '0;
			rstate_q <= RS_NORMAL;
		end else if (fire) begin
			held_q   <= held_d;
			owner_q  <= owner_d;
			count_q  <= count_d;
			rstate_q <= rstate_d;
		end
	end

	// A free mutex has no owner and no count.
	a_free_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!held_q |-> (owner_q == '0 && count_q == '0))
		else $error("free mutex keeps owner or count");

	// A held mutex always has a nonzero count.
	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> count_q != '0)
		else $error("held mutex with zero count");

	// A deadlock, wait or not-permitted refusal leaves ownership untouched.
	a_refused_stable: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (status == ST_DEADLOCK || status == ST_WAIT || status == ST_NOTPERM)
		|=> $stable(held_q) && $stable(owner_q) && $stable(count_q))
		else $error("refused request changed the lock");

endmodule

>>> rtl/mutex_lock_state_machine_core.sv
// Top level of the mutex lock cell: channels, configuration and pipeline registers.
//
// One POSIX-style mutex. Requests (lock, trylock, unlock, mark consistent)
// arrive on the req channel with a requester id, the owner's liveness and a
// force-release flag; every request returns exactly one item on the rsp
// channel with a status and the held flag, owner and recursion count left
// after the request.
// Both channels use valid/ready; an item moves when both are high.
// An accepted request passes from the request register through the decision
// logic into the result register. Throughput is one request per cycle while
// the receiver does not stall; the lock state is read, decided and written
// back as each request leaves the request register.
// If the receiver stalls, the result holds in its register and one more
// request waits in the request register; req.ready then drops.
// Configuration (mutex type, robustness, trylock support) is written through
// cfg_wr_en/cfg_index/cfg_wdata; the user must write it only while no request
// is in flight, which the block does not enforce. Reset clears the lock (free,
// owner 0, count 0, robust state normal), all configuration and every pending item.
module mutex_lock_state_machine_core
	import mlsm_pkg::*;
#(
	parameter int unsigned ID_BITS    = 8,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	mlsm_req_if.sink                 req,
	mlsm_rsp_if.source               rsp,
	input  logic                     cfg_wr_en,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	cfg_t cfg_q;

	logic               vld_s1;
	logic [1:0]         req_type_s1;
	logic [ID_BITS-1:0] id_s1;
	logic               alive_s1;
	logic               force_s1;

	logic                  out_vld_q;
	status_t               status_q;
	logic                  held_q;
	logic [ID_BITS-1:0]    owner_q;
	logic [COUNT_BITS-1:0] count_q;

	status_t               status_c;
	logic                  held_c;
	logic [ID_BITS-1:0]    owner_c;
	logic [COUNT_BITS-1:0] count_c;

	logic advance;

	// Stage 1 moves on whenever the result register is free or draining.
	assign advance   = vld_s1 && (!out_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MUTEX_TYPE: cfg_q.mutex_type      <= cfg_wdata[1:0];
				CFG_ROBUST:     cfg_q.robust_mode     <= cfg_wdata[0];
				CFG_TRYLOCK:    cfg_q.trylock_enabled <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			id_s1       <= req.requester_id;
			alive_s1    <= req.owner_alive;
			force_s1    <= req.force_release;
		end
	end

	mlsm_cell #(
		.ID_BITS    (ID_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_cell (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.fire          (advance),
		.req_type      (req_type_s1),
		.requester_id  (id_s1),
		.owner_alive   (alive_s1),
		.force_release (force_s1),
		.status        (status_c),
		.held_now      (held_c),
		.owner_now     (owner_c),
		.count_now     (count_c)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_c;
			held_q   <= held_c;
			owner_q  <= owner_c;
			count_q  <= count_c;
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.status    = status_q;
	assign rsp.held_now  = held_q;
	assign rsp.owner_now = owner_q;
	assign rsp.count_now = count_q;

endmodule
